// ===== rtl/mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared types, register codes, state encodings and palette shading for the
// escape-time pixel colouriser.
// ----------------------------------------------------------------------------
package mpc_pkg;

   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int ORIGIN_W    = 32;
   localparam int STEP_W      = 31;
   localparam int ITER_W      = 10;
   localparam int CHAN_W      = 8;
   localparam int T_W         = 8;
   localparam int DIVD_W      = ITER_W + T_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [ITER_W-1:0] ITER_LIMIT_RESET = 10'd96;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REAL_ORIGIN    = 3'd0,
      CSR_REAL_STEP      = 3'd1,
      CSR_IMAG_ORIGIN    = 3'd2,
      CSR_IMAG_STEP      = 3'd3,
      CSR_PALETTE_SELECT = 3'd4,
      CSR_ITER_LIMIT     = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PAL_EARTH = 2'd0,
      PAL_AIR   = 2'd1,
      PAL_FIRE  = 2'd2,
      PAL_WATER = 2'd3
   } palette_type;

   typedef struct packed {
      logic [ORIGIN_W-1:0] real_origin;
      logic [STEP_W-1:0]   real_step;
      logic [ORIGIN_W-1:0] imag_origin;
      logic [STEP_W-1:0]   imag_step;
      palette_type         palette_select;
      logic [ITER_W-1:0]   iter_limit;
   } cfg_type;

   typedef struct packed {
      logic [ITER_W-1:0] iter_count;
      logic              inside_set;
   } esc_result_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef enum logic [2:0] {
      ESC_IDLE,
      ESC_MUL,
      ESC_SUM,
      ESC_UPD,
      ESC_FIN
   } esc_state_type;

   typedef enum logic [1:0] {
      SHD_IDLE,
      SHD_DIV,
      SHD_OUT
   } shd_state_type;

   // floor(x / 5) by reciprocal, exact for x below 2^12
   function automatic logic [11:0] div5(input logic [11:0] x);
      logic [27:0] p;
      p = 28'(x) * 28'd52429;
      return 12'(p >> 18);
   endfunction

   // floor(x / 255), exact for x below 65280, where the quotient fits in eight bits
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] s;
      s = 17'(x) + 17'(x >> 8) + 17'd1;
      return 8'(s >> 8);
   endfunction

   function automatic logic [CHAN_W-1:0] sat8(input logic [8:0] v);
      return (v > 9'd255) ? 8'hff : v[7:0];
   endfunction

   function automatic rgb_type shade_colour(input palette_type pal, input logic [T_W-1:0] t);
      logic [11:0] t12;
      logic [8:0]  r;
      logic [8:0]  g;
      logic [8:0]  b;
      rgb_type     c;
      t12 = 12'(t);
      unique case (pal)
         PAL_EARTH: begin
            r = 9'd40 + 9'((t12 * 12'd5) >> 3);
            g = 9'd24 + 9'((t12 * 12'd3) >> 2);
            b = 9'd12 + 9'(div5(t12));
         end
         PAL_AIR: begin
            r = 9'd70 + 9'((t12 * 12'd3) >> 2);
            g = 9'd110 + 9'((t12 * 12'd9) >> 4);
            b = 9'd150 + 9'(div5(t12 * 12'd2));
         end
         PAL_FIRE: begin
            r = 9'd90 + 9'(div5(t12 * 12'd13) >> 2);
            g = {1'b0, div255(16'(t) * 16'(t))};
            b = 9'(t >> 3);
         end
         PAL_WATER: begin
            r = 9'(t >> 3);
            g = 9'd35 + 9'(div5(t12 * 12'd3));
            b = 9'd90 + 9'(div5(t12 * 12'd13) >> 2);
         end
      endcase
      c.red   = sat8(r);
      c.green = sat8(g);
      c.blue  = sat8(b);
      return c;
   endfunction

endpackage

// ===== rtl/mandelbrot_pixel_colorizer_unit.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_colorizer_unit
// Escape-time pixel colouriser: maps a pixel to a complex point, iterates
// z = z*z + c and shades the escape count by one of four palettes.
// ----------------------------------------------------------------------------
// A pixel occupies the escape loop until it escapes or reaches iter_limit
// (96 by default), and this loop sets the throughput. Each iteration runs
// through registered split partial products of the three magnitude
// multipliers, their registered sum, then the escape test and z update.
// Coordinate mapping (registered stages ahead of a two-entry queue) and
// shading (a bit-serial divider) run alongside the loop on neighbouring
// pixels, and a finished result waits in an output register without holding
// up the next pixel. Configuration is written through the csr port; the user
// must write it only while the block is idle, and the block itself does not
// enforce this.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_colorizer_unit #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 28
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [COORD_BITS-1:0]             req_pixel_col,
   input  logic [COORD_BITS-1:0]             req_pixel_row,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mpc_pkg::CHAN_W-1:0]        rsp_red,
   output logic [mpc_pkg::CHAN_W-1:0]        rsp_green,
   output logic [mpc_pkg::CHAN_W-1:0]        rsp_blue,
   output logic [mpc_pkg::ITER_W-1:0]        rsp_iter_count,
   output logic                              rsp_inside_set,
   input  logic                              csr_write,
   input  logic [mpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int C_W = FRAC_BITS + 4;

   mpc_pkg::cfg_type          cfg_ff, cfg_in;
   logic                      map_valid;
   logic                      map_ready;
   logic [C_W-1:0]            map_cx;
   logic [C_W-1:0]            map_cy;
   logic                      pnt_valid;
   logic                      pnt_ready;
   logic [2*C_W-1:0]          pnt_data;
   logic                      esc_valid;
   logic                      esc_ready;
   mpc_pkg::esc_result_type   esc_result;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            mpc_pkg::CSR_REAL_ORIGIN:    cfg_in.real_origin    = csr_wdata;
            mpc_pkg::CSR_REAL_STEP:      cfg_in.real_step      = csr_wdata[mpc_pkg::STEP_W-1:0];
            mpc_pkg::CSR_IMAG_ORIGIN:    cfg_in.imag_origin    = csr_wdata;
            mpc_pkg::CSR_IMAG_STEP:      cfg_in.imag_step      = csr_wdata[mpc_pkg::STEP_W-1:0];
            mpc_pkg::CSR_PALETTE_SELECT: begin
               cfg_in.palette_select = mpc_pkg::palette_type'(csr_wdata[1:0]);
            end
            mpc_pkg::CSR_ITER_LIMIT:     cfg_in.iter_limit     = csr_wdata[mpc_pkg::ITER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.real_origin    <= '0;
         cfg_ff.real_step      <= '0;
         cfg_ff.imag_origin    <= '0;
         cfg_ff.imag_step      <= '0;
         cfg_ff.palette_select <= mpc_pkg::PAL_EARTH;
         cfg_ff.iter_limit     <= mpc_pkg::ITER_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mpc_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .pixel_col (req_pixel_col),
      .pixel_row (req_pixel_row),
      .out_valid (map_valid),
      .out_ready (map_ready),
      .out_cx    (map_cx),
      .out_cy    (map_cy)
   );

   mpc_queue #(
      .DATA_W (2 * C_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (map_valid),
      .in_ready  (map_ready),
      .in_data   ({map_cx, map_cy}),
      .out_valid (pnt_valid),
      .out_ready (pnt_ready),
      .out_data  (pnt_data)
   );

   mpc_escape #(
      .FRAC_BITS (FRAC_BITS)
   ) u_escape (
      .clock      (clock),
      .reset      (reset),
      .iter_limit (cfg_ff.iter_limit),
      .in_valid   (pnt_valid),
      .in_ready   (pnt_ready),
      .in_cx      (pnt_data[2*C_W-1:C_W]),
      .in_cy      (pnt_data[C_W-1:0]),
      .out_valid  (esc_valid),
      .out_ready  (esc_ready),
      .out_result (esc_result)
   );

   mpc_shade u_shade (
      .clock          (clock),
      .reset          (reset),
      .palette_select (cfg_ff.palette_select),
      .iter_limit     (cfg_ff.iter_limit),
      .in_valid       (esc_valid),
      .in_ready       (esc_ready),
      .in_result      (esc_result),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .out_red        (rsp_red),
      .out_green      (rsp_green),
      .out_blue       (rsp_blue),
      .out_iter_count (rsp_iter_count),
      .out_inside_set (rsp_inside_set)
   );

endmodule

// ===== rtl/mpc_front.sv =====
// ----------------------------------------------------------------------------
// mpc_front
// Accepts pixel coordinates and maps them to a clamped complex point in two
// registered stages: index times step, then origin add and clamp to [-8, 8).
// ----------------------------------------------------------------------------
module mpc_front #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 28
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mpc_pkg::cfg_type           cfg,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [COORD_BITS-1:0]      pixel_col,
   input  logic [COORD_BITS-1:0]      pixel_row,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [FRAC_BITS+3:0]       out_cx,
   output logic [FRAC_BITS+3:0]       out_cy
);

   localparam int PROD_W = COORD_BITS + mpc_pkg::STEP_W;
   localparam int SUM_W  = PROD_W + 2;
   localparam int C_W    = FRAC_BITS + 4;
   localparam int SAT_W  = ((SUM_W > C_W) ? SUM_W : C_W) + 1;

   logic              s1_valid_ff, s1_valid_in;
   logic              s2_valid_ff, s2_valid_in;
   logic [PROD_W-1:0] prod_re_ff, prod_re_in;
   logic [PROD_W-1:0] prod_im_ff, prod_im_in;
   logic [C_W-1:0]    cx_ff, cx_in;
   logic [C_W-1:0]    cy_ff, cy_in;
   logic [SUM_W-1:0]  sum_re;
   logic [SUM_W-1:0]  sum_im;
   logic              s1_take;
   logic              s2_load;

   function automatic logic [C_W-1:0] clamp(input logic [SUM_W-1:0] v);
      logic [SAT_W-1:0]     e;
      logic [SAT_W-C_W:0]   hi;
      e  = {{(SAT_W-SUM_W){v[SUM_W-1]}}, v};
      hi = e[SAT_W-1:C_W-1];
      if (hi == '0 || hi == '1) begin
         return e[C_W-1:0];
      end else if (e[SAT_W-1]) begin
         return {1'b1, {(C_W-1){1'b0}}};
      end else begin
         return {1'b0, {(C_W-1){1'b1}}};
      end
   endfunction

   always_comb begin
      s2_load  = s1_valid_ff && (!s2_valid_ff || out_ready);
      in_ready = !s1_valid_ff || s2_load;
      s1_take  = in_valid && in_ready;

      if (s1_take) begin
         s1_valid_in = 1'b1;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s2_load) begin
         s2_valid_in = 1'b1;
      end else if (out_ready) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end

      prod_re_in = s1_take ? PROD_W'(pixel_col) * PROD_W'(cfg.real_step) : prod_re_ff;
      prod_im_in = s1_take ? PROD_W'(pixel_row) * PROD_W'(cfg.imag_step) : prod_im_ff;

      sum_re = {{(SUM_W-mpc_pkg::ORIGIN_W){cfg.real_origin[mpc_pkg::ORIGIN_W-1]}},
                cfg.real_origin} + SUM_W'(prod_re_ff);
      sum_im = {{(SUM_W-mpc_pkg::ORIGIN_W){cfg.imag_origin[mpc_pkg::ORIGIN_W-1]}},
                cfg.imag_origin} + SUM_W'(prod_im_ff);

      cx_in = s2_load ? clamp(sum_re) : cx_ff;
      cy_in = s2_load ? clamp(sum_im) : cy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_re_ff <= prod_re_in;
      prod_im_ff <= prod_im_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_cx    = cx_ff;
   assign out_cy    = cy_ff;

endmodule

// ===== rtl/mpc_queue.sv =====
// ----------------------------------------------------------------------------
// mpc_queue
// Short first-in first-out queue between the mapping front end and the
// escape loop, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module mpc_queue #(
   parameter int DATA_W = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   localparam int CNT_W = mpc_pkg::QUEUE_PTR_W + 1;

   logic [DATA_W-1:0]                  mem_ff [mpc_pkg::QUEUE_DEPTH];
   logic [mpc_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [mpc_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   logic                               push;
   logic                               pop;

   always_comb begin
      in_ready  = count_ff != CNT_W'(mpc_pkg::QUEUE_DEPTH);
      out_valid = count_ff != '0;
      push      = in_valid && in_ready;
      pop       = out_valid && out_ready;
      wr_ptr_in = push ? wr_ptr_ff + mpc_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + mpc_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
      out_data  = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/mpc_escape.sv =====
// ----------------------------------------------------------------------------
// mpc_escape
// Escape-time loop z = z*z + c. Three magnitude multipliers, each split into
// four registered partial products, then a registered sum and truncation,
// then the escape test and z update.
// ----------------------------------------------------------------------------
module mpc_escape #(
   parameter int FRAC_BITS = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mpc_pkg::ITER_W-1:0]    iter_limit,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [FRAC_BITS+3:0]          in_cx,
   input  logic [FRAC_BITS+3:0]          in_cy,
   output logic                          out_valid,
   input  logic                          out_ready,
   output mpc_pkg::esc_result_type       out_result
);

   localparam int C_W    = FRAC_BITS + 4;
   localparam int Z_W    = FRAC_BITS + 5;
   localparam int MAG_W  = FRAC_BITS + 4;
   localparam int LO_W   = (MAG_W + 1) / 2;
   localparam int HI_W   = MAG_W - LO_W;
   localparam int PROD_W = 2 * MAG_W;
   localparam int SQ_W   = FRAC_BITS + 8;
   localparam int SUM_W  = FRAC_BITS + 9;
   localparam int UPD_W  = FRAC_BITS + 10;
   localparam int N_MUL  = 3;
   localparam int P_XX   = 0;
   localparam int P_YY   = 1;
   localparam int P_XY   = 2;

   localparam logic [SUM_W-1:0] ESC_LIM = SUM_W'(4) << FRAC_BITS;

   mpc_pkg::esc_state_type       state_ff, state_in;
   logic [C_W-1:0]               cx_ff, cx_in;
   logic [C_W-1:0]               cy_ff, cy_in;
   logic [Z_W-1:0]               zx_ff, zx_in;
   logic [Z_W-1:0]               zy_ff, zy_in;
   logic [mpc_pkg::ITER_W-1:0]   n_ff, n_in;
   logic                         inside_ff, inside_in;
   logic                         out_valid_ff, out_valid_in;
   mpc_pkg::esc_result_type      result_ff, result_in;

   logic [2*LO_W-1:0]            pll_ff [N_MUL];
   logic [LO_W+HI_W-1:0]         plh_ff [N_MUL];
   logic [LO_W+HI_W-1:0]         phl_ff [N_MUL];
   logic [2*HI_W-1:0]            phh_ff [N_MUL];
   logic [SQ_W-1:0]              sq_ff  [N_MUL];
   logic [2*LO_W-1:0]            pll_in [N_MUL];
   logic [LO_W+HI_W-1:0]         plh_in [N_MUL];
   logic [LO_W+HI_W-1:0]         phl_in [N_MUL];
   logic [2*HI_W-1:0]            phh_in [N_MUL];
   logic [SQ_W-1:0]              sq_in  [N_MUL];
   logic [PROD_W-1:0]            full   [N_MUL];
   logic [MAG_W-1:0]             opa    [N_MUL];
   logic [MAG_W-1:0]             opb    [N_MUL];

   logic [MAG_W-1:0]             mag_x;
   logic [MAG_W-1:0]             mag_y;
   logic [SUM_W-1:0]             sum_sq;
   logic                         escape;
   logic                         at_limit;
   logic                         out_free;
   logic [UPD_W-1:0]             nx;
   logic [UPD_W-1:0]             xy2;
   logic [UPD_W-1:0]             ny;

   // magnitudes and split partial products
   always_comb begin
      mag_x = zx_ff[Z_W-1] ? MAG_W'(-zx_ff) : MAG_W'(zx_ff);
      mag_y = zy_ff[Z_W-1] ? MAG_W'(-zy_ff) : MAG_W'(zy_ff);
      opa[P_XX] = mag_x;
      opb[P_XX] = mag_x;
      opa[P_YY] = mag_y;
      opb[P_YY] = mag_y;
      opa[P_XY] = mag_x;
      opb[P_XY] = mag_y;
      for (int k = 0; k < N_MUL; k++) begin
         pll_in[k] = (2*LO_W)'(opa[k][LO_W-1:0]) * (2*LO_W)'(opb[k][LO_W-1:0]);
         plh_in[k] = (LO_W+HI_W)'(opa[k][LO_W-1:0]) * (LO_W+HI_W)'(opb[k][MAG_W-1:LO_W]);
         phl_in[k] = (LO_W+HI_W)'(opa[k][MAG_W-1:LO_W]) * (LO_W+HI_W)'(opb[k][LO_W-1:0]);
         phh_in[k] = (2*HI_W)'(opa[k][MAG_W-1:LO_W]) * (2*HI_W)'(opb[k][MAG_W-1:LO_W]);
         full[k]   = PROD_W'(pll_ff[k])
                   + ((PROD_W'(plh_ff[k]) + PROD_W'(phl_ff[k])) << LO_W)
                   + (PROD_W'(phh_ff[k]) << (2*LO_W));
         sq_in[k]  = full[k][FRAC_BITS +: SQ_W];
      end
   end

   // escape test and update
   always_comb begin
      sum_sq   = SUM_W'(sq_ff[P_XX]) + SUM_W'(sq_ff[P_YY]);
      escape   = sum_sq > ESC_LIM;
      at_limit = n_ff >= iter_limit;
      out_free = !out_valid_ff || out_ready;
      nx  = UPD_W'(sq_ff[P_XX]) - UPD_W'(sq_ff[P_YY])
          + {{(UPD_W-C_W){cx_ff[C_W-1]}}, cx_ff};
      xy2 = UPD_W'({sq_ff[P_XY], 1'b0});
      ny  = ((zx_ff[Z_W-1] ^ zy_ff[Z_W-1]) ? -xy2 : xy2)
          + {{(UPD_W-C_W){cy_ff[C_W-1]}}, cy_ff};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpc_pkg::ESC_IDLE: begin
            if (in_valid) begin
               state_in = mpc_pkg::ESC_MUL;
            end
         end
         mpc_pkg::ESC_MUL: begin
            state_in = at_limit ? mpc_pkg::ESC_FIN : mpc_pkg::ESC_SUM;
         end
         mpc_pkg::ESC_SUM: begin
            state_in = mpc_pkg::ESC_UPD;
         end
         mpc_pkg::ESC_UPD: begin
            state_in = escape ? mpc_pkg::ESC_FIN : mpc_pkg::ESC_MUL;
         end
         mpc_pkg::ESC_FIN: begin
            if (out_free) begin
               state_in = mpc_pkg::ESC_IDLE;
            end
         end
         default: begin
            state_in = mpc_pkg::ESC_IDLE;
         end
      endcase
   end

   always_comb begin
      in_ready     = state_ff == mpc_pkg::ESC_IDLE;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      zx_in        = zx_ff;
      zy_in        = zy_ff;
      n_in         = n_ff;
      inside_in    = inside_ff;
      result_in    = result_ff;
      out_valid_in = out_valid_ff && !out_ready;
      unique case (state_ff)
         mpc_pkg::ESC_IDLE: begin
            if (in_valid) begin
               cx_in = in_cx;
               cy_in = in_cy;
               zx_in = '0;
               zy_in = '0;
               n_in  = '0;
            end
         end
         mpc_pkg::ESC_MUL: begin
            inside_in = at_limit;
         end
         mpc_pkg::ESC_UPD: begin
            if (!escape) begin
               zx_in = nx[Z_W-1:0];
               zy_in = ny[Z_W-1:0];
               n_in  = n_ff + mpc_pkg::ITER_W'(1);
            end
         end
         mpc_pkg::ESC_FIN: begin
            if (out_free) begin
               result_in.iter_count = n_ff;
               result_in.inside_set = inside_ff;
               out_valid_in         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpc_pkg::ESC_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      zx_ff     <= zx_in;
      zy_ff     <= zy_in;
      n_ff      <= n_in;
      inside_ff <= inside_in;
      result_ff <= result_in;
      for (int k = 0; k < N_MUL; k++) begin
         pll_ff[k] <= pll_in[k];
         plh_ff[k] <= plh_in[k];
         phl_ff[k] <= phl_in[k];
         phh_ff[k] <= phh_in[k];
         sq_ff[k]  <= sq_in[k];
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

// ===== rtl/mpc_shade.sv =====
// ----------------------------------------------------------------------------
// mpc_shade
// Scales the iteration count to t = n*255/limit with a bit-serial divider
// and shades it by the selected palette into the result register; a result
// inside the set skips the divider and is shaded black.
// ----------------------------------------------------------------------------
module mpc_shade (
   input  logic                          clock,
   input  logic                          reset,
   input  mpc_pkg::palette_type          palette_select,
   input  logic [mpc_pkg::ITER_W-1:0]    iter_limit,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  mpc_pkg::esc_result_type       in_result,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [mpc_pkg::CHAN_W-1:0]    out_red,
   output logic [mpc_pkg::CHAN_W-1:0]    out_green,
   output logic [mpc_pkg::CHAN_W-1:0]    out_blue,
   output logic [mpc_pkg::ITER_W-1:0]    out_iter_count,
   output logic                          out_inside_set
);

   localparam int CNT_W = $clog2(mpc_pkg::T_W);

   mpc_pkg::shd_state_type           state_ff, state_in;
   mpc_pkg::esc_result_type          res_ff, res_in;
   logic [mpc_pkg::DIVD_W-1:0]       rem_ff, rem_in;
   logic [mpc_pkg::DIVD_W-1:0]       dvs_ff, dvs_in;
   logic [mpc_pkg::T_W-1:0]          quo_ff, quo_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic                             out_valid_ff, out_valid_in;
   mpc_pkg::rgb_type                 rgb_ff, rgb_in;
   mpc_pkg::esc_result_type          out_res_ff, out_res_in;
   logic                             ge;
   logic                             out_free;

   always_comb begin
      ge       = rem_ff >= dvs_ff;
      out_free = !out_valid_ff || out_ready;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpc_pkg::SHD_IDLE: begin
            if (in_valid) begin
               state_in = in_result.inside_set ? mpc_pkg::SHD_OUT : mpc_pkg::SHD_DIV;
            end
         end
         mpc_pkg::SHD_DIV: begin
            if (cnt_ff == '0) begin
               state_in = mpc_pkg::SHD_OUT;
            end
         end
         mpc_pkg::SHD_OUT: begin
            if (out_free) begin
               state_in = mpc_pkg::SHD_IDLE;
            end
         end
         default: begin
            state_in = mpc_pkg::SHD_IDLE;
         end
      endcase
   end

   always_comb begin
      in_ready     = state_ff == mpc_pkg::SHD_IDLE;
      res_in       = res_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      rgb_in       = rgb_ff;
      out_res_in   = out_res_ff;
      out_valid_in = out_valid_ff && !out_ready;
      unique case (state_ff)
         mpc_pkg::SHD_IDLE: begin
            if (in_valid) begin
               res_in = in_result;
               rem_in = (mpc_pkg::DIVD_W'(in_result.iter_count) << mpc_pkg::T_W)
                      - mpc_pkg::DIVD_W'(in_result.iter_count);
               dvs_in = mpc_pkg::DIVD_W'(iter_limit) << (mpc_pkg::T_W - 1);
               quo_in = '0;
               cnt_in = CNT_W'(mpc_pkg::T_W - 1);
            end
         end
         mpc_pkg::SHD_DIV: begin
            if (ge) begin
               rem_in = rem_ff - dvs_ff;
            end
            quo_in = {quo_ff[mpc_pkg::T_W-2:0], ge};
            dvs_in = dvs_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         mpc_pkg::SHD_OUT: begin
            if (out_free) begin
               out_res_in   = res_ff;
               rgb_in       = res_ff.inside_set ? '0
                                                : mpc_pkg::shade_colour(palette_select, quo_ff);
               out_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpc_pkg::SHD_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff     <= res_in;
      rem_ff     <= rem_in;
      dvs_ff     <= dvs_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      rgb_ff     <= rgb_in;
      out_res_ff <= out_res_in;
   end

   assign out_valid      = out_valid_ff;
   assign out_red        = rgb_ff.red;
   assign out_green      = rgb_ff.green;
   assign out_blue       = rgb_ff.blue;
   assign out_iter_count = out_res_ff.iter_count;
   assign out_inside_set = out_res_ff.inside_set;

endmodule

// ===== tb/tb_mandelbrot_pixel_colorizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_pixel_colorizer_unit
// Self-checking bench for the escape-time pixel colouriser. A directed set of
// scenes covers reset values, every palette, limits of zero, one and the
// maximum, the set boundary and saturated coordinates. Random scenes and
// random pixels follow. Each accepted pixel is coloured by a fixed-point
// escape-time predictor and each result transfer is checked against it.
// ----------------------------------------------------------------------------
module tb_mandelbrot_pixel_colorizer_unit;

   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 28;

   typedef struct packed {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
   } pixel_coord_type;

   typedef struct packed {
      logic [mpc_pkg::CHAN_W-1:0] red;
      logic [mpc_pkg::CHAN_W-1:0] green;
      logic [mpc_pkg::CHAN_W-1:0] blue;
      logic [mpc_pkg::ITER_W-1:0] iter_count;
      logic                       inside_set;
   } shaded_pixel_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [COORD_BITS-1:0]           req_pixel_col = '0;
   logic [COORD_BITS-1:0]           req_pixel_row = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [mpc_pkg::CHAN_W-1:0]      rsp_red;
   logic [mpc_pkg::CHAN_W-1:0]      rsp_green;
   logic [mpc_pkg::CHAN_W-1:0]      rsp_blue;
   logic [mpc_pkg::ITER_W-1:0]      rsp_iter_count;
   logic                            rsp_inside_set;
   logic                            csr_write = 1'b0;
   logic [mpc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mpc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   mpc_pkg::cfg_type  scene;
   pixel_coord_type   pending_pixels[$];
   shaded_pixel_type  expected_pixels[$];
   int                accepted_pixels;
   int                checked_pixels;
   int                bad_pixels;
   int                inside_total;
   int                deepest_escape;
   int                scene_count;
   logic [3:0]        palettes_seen;
   int                hold_cycles;
   bit                hold_used;

   mandelbrot_pixel_colorizer_unit #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel_col (req_pixel_col),
      .req_pixel_row (req_pixel_row),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_iter_count(rsp_iter_count),
      .rsp_inside_set(rsp_inside_set),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // product of two fixed-point values, magnitude truncated toward zero
   function automatic longint fixed_mul(input longint a, input longint b);
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [127:0] prod;
      logic [63:0]  m;
      ma   = (a < 0) ? -a : a;
      mb   = (b < 0) ? -b : b;
      prod = {64'd0, ma} * {64'd0, mb};
      m    = 64'(prod >> FRAC_BITS) & 64'h3FFF_FFFF_FFFF_FFFF;
      return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
   endfunction

   // one part of c, saturated to [-8.0, 8.0 - 1 lsb]
   function automatic longint axis_point(input longint origin, input longint step,
                                         input logic [COORD_BITS-1:0] idx);
      longint v;
      longint lim;
      lim = 64'sd8 << FRAC_BITS;
      v   = origin + longint'(idx) * step;
      if (v > lim - 1) v = lim - 1;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   function automatic shaded_pixel_type colour_pixel(input mpc_pkg::cfg_type s,
                                                     input logic [COORD_BITS-1:0] col,
                                                     input logic [COORD_BITS-1:0] row);
      longint           cx;
      longint           cy;
      longint           zx;
      longint           zy;
      longint           sx;
      longint           sy;
      longint           nx;
      longint           four;
      int               n;
      int               lim;
      int               t;
      int               r;
      int               g;
      int               b;
      shaded_pixel_type p;
      cx   = axis_point($signed(s.real_origin), longint'(s.real_step), col);
      cy   = axis_point($signed(s.imag_origin), longint'(s.imag_step), row);
      four = 64'sd4 << FRAC_BITS;
      lim  = int'(s.iter_limit);
      zx   = 0;
      zy   = 0;
      n    = 0;
      while (n < lim) begin
         sx = fixed_mul(zx, zx);
         sy = fixed_mul(zy, zy);
         if (sx + sy > four) break;
         nx = sx - sy + cx;
         zy = 2 * fixed_mul(zx, zy) + cy;
         zx = nx;
         n++;
      end
      r = 0;
      g = 0;
      b = 0;
      if (n < lim) begin
         t = n * 255 / lim;
         unique case (s.palette_select)
            mpc_pkg::PAL_EARTH: begin
               r = 40 + t * 5 / 8;
               g = 24 + t * 3 / 4;
               b = 12 + t / 5;
            end
            mpc_pkg::PAL_AIR: begin
               r = 70 + t * 3 / 4;
               g = 110 + t * 9 / 16;
               b = 150 + t * 2 / 5;
            end
            mpc_pkg::PAL_FIRE: begin
               r = 90 + t * 13 / 20;
               g = t * t / 255;
               b = t / 8;
            end
            default: begin
               r = t / 8;
               g = 35 + t * 3 / 5;
               b = 90 + t * 13 / 20;
            end
         endcase
      end
      p.red        = (r > 255) ? 8'd255 : 8'(r);
      p.green      = (g > 255) ? 8'd255 : 8'(g);
      p.blue       = (b > 255) ? 8'd255 : 8'(b);
      p.iter_count = mpc_pkg::ITER_W'(n);
      p.inside_set = (n >= lim);
      return p;
   endfunction

   function automatic mpc_pkg::cfg_type make_scene(input logic [31:0] ro, input logic [30:0] rs,
                                                   input logic [31:0] io, input logic [30:0] is,
                                                   input mpc_pkg::palette_type pal,
                                                   input logic [9:0] lim);
      mpc_pkg::cfg_type s;
      s.real_origin    = ro;
      s.real_step      = rs;
      s.imag_origin    = io;
      s.imag_step      = is;
      s.palette_select = pal;
      s.iter_limit     = lim;
      return s;
   endfunction

   task automatic put_reg(input mpc_pkg::csr_index_type idx,
                          input logic [mpc_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pixels.size() != 0 || req_valid || expected_pixels.size() != 0);
   endtask

   // registers change only with nothing in flight
   task automatic apply_scene(input mpc_pkg::cfg_type s);
      wait_drained();
      put_reg(mpc_pkg::CSR_REAL_ORIGIN, s.real_origin);
      put_reg(mpc_pkg::CSR_REAL_STEP, {1'b0, s.real_step});
      put_reg(mpc_pkg::CSR_IMAG_ORIGIN, s.imag_origin);
      put_reg(mpc_pkg::CSR_IMAG_STEP, {1'b0, s.imag_step});
      put_reg(mpc_pkg::CSR_PALETTE_SELECT, mpc_pkg::CSR_DATA_W'(s.palette_select));
      put_reg(mpc_pkg::CSR_ITER_LIMIT, mpc_pkg::CSR_DATA_W'(s.iter_limit));
      @(posedge clock);
      csr_write <= 1'b0;
      scene = s;
      scene_count++;
      palettes_seen[s.palette_select] = 1'b1;
      @(negedge clock);
   endtask

   task automatic queue_pixel(input int col, input int row);
      pixel_coord_type c;
      c.col = COORD_BITS'(col);
      c.row = COORD_BITS'(row);
      pending_pixels.push_back(c);
   endtask

   // driver: a new pixel is offered only once the previous one has transferred
   always @(posedge clock) begin
      int              send_idle;
      pixel_coord_type nxt;
      if (reset) begin
         req_valid       <= 1'b0;
         accepted_pixels <= 0;
      end else begin
         send_idle = (accepted_pixels < 250) ? 21 : (accepted_pixels < 500) ? 87 : 0;
         if (req_valid && req_ready) begin
            expected_pixels.push_back(colour_pixel(scene, req_pixel_col, req_pixel_row));
            accepted_pixels <= accepted_pixels + 1;
         end
         if (!req_valid || req_ready) begin
            if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               nxt = pending_pixels.pop_front();
               req_valid     <= 1'b1;
               req_pixel_col <= nxt.col;
               req_pixel_row <= nxt.row;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long output stall while the input queue is well stocked
   always @(negedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
         hold_used   <= 1'b0;
      end else if (!hold_used && accepted_pixels >= 300 && pending_pixels.size() >= 12) begin
         hold_cycles <= 600;
         hold_used   <= 1'b1;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   // monitor: each result transfer against the oldest prediction
   always @(posedge clock) begin
      int               recv_idle;
      shaded_pixel_type want;
      shaded_pixel_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         recv_idle = (accepted_pixels < 250) ? 87 : (accepted_pixels < 500) ? 21 : 0;
         if (rsp_valid && rsp_ready) begin
            got = {rsp_red, rsp_green, rsp_blue, rsp_iter_count, rsp_inside_set};
            if (expected_pixels.size() == 0) begin
               bad_pixels++;
               if (bad_pixels <= 10)
                  $display("%t: unexpected result rgb %0d/%0d/%0d n %0d inside %0d", $time,
                           got.red, got.green, got.blue, got.iter_count, got.inside_set);
            end else begin
               want = expected_pixels.pop_front();
               checked_pixels++;
               if (want.inside_set) inside_total++;
               else if (int'(want.iter_count) > deepest_escape)
                  deepest_escape = int'(want.iter_count);
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.iter_count !== want.iter_count ||
                   got.inside_set !== want.inside_set) begin
                  bad_pixels++;
                  if (bad_pixels <= 10) begin
                     $display("%t: pixel %0d mismatch", $time, checked_pixels);
                     $display("   expected rgb %0d/%0d/%0d n %0d inside %0d",
                              want.red, want.green, want.blue, want.iter_count,
                              want.inside_set);
                     $display("   got      rgb %0d/%0d/%0d n %0d inside %0d",
                              got.red, got.green, got.blue, got.iter_count,
                              got.inside_set);
                  end
               end
            end
         end
         rsp_ready <= (hold_cycles == 0) && ($urandom_range(0, 99) >= recv_idle);
      end
   end

   initial begin
      #20_000_000;
      $display("timeout with %0d results outstanding", expected_pixels.size());
      $display("tb_mandelbrot_pixel_colorizer_unit failed");
      $finish;
   end

   initial begin
      mpc_pkg::cfg_type s;
      int               random_items;
      int               count;
      int               pick;
      int               col;
      int               row;
      checked_pixels  = 0;
      bad_pixels      = 0;
      inside_total    = 0;
      deepest_escape  = 0;
      scene_count     = 0;
      palettes_seen   = '0;
      scene           = '0;
      scene.iter_limit = mpc_pkg::ITER_LIMIT_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values: c is zero everywhere
      queue_pixel(0, 0);
      queue_pixel(4095, 4095);

      // full set view, corners, interior, the point -2 and the cusp at 0.25
      apply_scene(make_scene(32'hE000_0000, 31'd196608, 32'hE800_0000, 31'd196608,
                             mpc_pkg::PAL_EARTH, 10'd32));
      queue_pixel(0, 0);
      queue_pixel(4095, 4095);
      queue_pixel(4095, 0);
      queue_pixel(0, 4095);
      queue_pixel(2048, 2048);
      queue_pixel(1365, 2048);
      queue_pixel(0, 2048);
      queue_pixel(3072, 2048);

      // limit of one
      apply_scene(make_scene(32'hE000_0000, 31'd196608, 32'hE800_0000, 31'd196608,
                             mpc_pkg::PAL_AIR, 10'd1));
      queue_pixel(0, 0);
      queue_pixel(2048, 2048);

      // largest limit
      apply_scene(make_scene(32'h0, 31'd262144, 32'h0, 31'd262144, mpc_pkg::PAL_FIRE,
                             10'd1023));
      queue_pixel(0, 0);
      queue_pixel(4095, 4095);

      // zero limit
      apply_scene(make_scene(32'h0, 31'd262144, 32'h0, 31'd262144, mpc_pkg::PAL_WATER,
                             10'd0));
      queue_pixel(1, 2);
      queue_pixel(4095, 4095);

      // extreme origins and steps, coordinates saturate
      apply_scene(make_scene(32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                             mpc_pkg::PAL_FIRE, 10'd1023));
      queue_pixel(0, 0);
      queue_pixel(4095, 4095);
      queue_pixel(4095, 0);
      queue_pixel(0, 4095);

      random_items = 0;
      while (random_items < 750) begin
         if ($urandom_range(0, 9) == 0) begin
            s.real_origin = $urandom;
            s.imag_origin = $urandom;
         end else begin
            s.real_origin = 32'(-671088640 + int'($urandom_range(0, 939524096)));
            s.imag_origin = 32'(-402653184 + int'($urandom_range(0, 805306368)));
         end
         s.real_step = ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                  : 31'($urandom_range(0, 262144));
         s.imag_step = ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                  : 31'($urandom_range(0, 262144));
         s.palette_select = mpc_pkg::palette_type'($urandom_range(0, 3));
         pick = $urandom_range(0, 99);
         if (pick < 80) s.iter_limit = 10'($urandom_range(1, 64));
         else if (pick < 95) s.iter_limit = 10'($urandom_range(65, 255));
         else s.iter_limit = 10'($urandom_range(256, 1023));
         count = (s.iter_limit > 64) ? $urandom_range(3, 6) : $urandom_range(16, 40);
         apply_scene(s);
         for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 15) == 0) begin
               col = $urandom_range(0, 1) ? 4095 : 0;
               row = $urandom_range(0, 1) ? 4095 : 0;
            end else begin
               col = $urandom_range(0, 4095);
               row = $urandom_range(0, 4095);
            end
            queue_pixel(col, row);
         end
         random_items += count;
      end

      wait_drained();
      repeat (40) @(negedge clock);
      $display("checked %0d pixels over %0d scenes: %0d inside the set, deepest escape %0d",
               checked_pixels, scene_count, inside_total, deepest_escape);
      $display("palettes used %b, long output stall applied %0d", palettes_seen, hold_used);
      if (bad_pixels == 0 && expected_pixels.size() == 0) begin
         $display("tb_mandelbrot_pixel_colorizer_unit passed");
      end else begin
         $display("%0d mismatches, %0d results missing", bad_pixels, expected_pixels.size());
         $display("tb_mandelbrot_pixel_colorizer_unit failed");
      end
      $finish;
   end

endmodule
